[hw/rtl/lwkc_pkg.sv]
// Shared types, sizes and keyword tables for the Lua word keyword classifier.
// Used by lwkc_scan, lwkc_match and lua_word_keyword_classifier.
// No dependencies.
package lwkc_pkg;

   // sizes
   localparam int MAX_WORD_LEN = 8;
   localparam int CHAR_W       = 8;
   localparam int WORD_W       = CHAR_W * MAX_WORD_LEN;
   localparam int LEN_W        = 16;
   localparam int KIND_W       = 5;
   localparam int KW_LEN_W     = 5;
   localparam int NUM_KW       = 22;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   typedef logic [CHAR_W-1:0]   char_type;
   typedef logic [WORD_W-1:0]   word_type;
   typedef logic [LEN_W-1:0]    len_type;
   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [KW_LEN_W-1:0] kw_len_type;

   localparam len_type  LEN_MAX    = {LEN_W{1'b1}};
   localparam kind_type KIND_IDENT = '0;

   // character codes
   localparam char_type CHAR_LF    = 8'h0A;
   localparam char_type CHAR_US    = 8'h5F;
   localparam char_type CHAR_0     = 8'h30;
   localparam char_type CHAR_9     = 8'h39;
   localparam char_type CHAR_LO_A  = 8'h61;
   localparam char_type CHAR_LO_Z  = 8'h7A;
   localparam char_type CHAR_UP_A  = 8'h41;
   localparam char_type CHAR_UP_Z  = 8'h5A;

   // register index of the top-level disable flag
   localparam logic CSR_IDX_TOP_DISABLE = 1'b0;

   // Keyword text, right-aligned: last character in the low byte, zero padded.
   // The scanner shifts characters in at the low end, so a stored word
   // compares against these directly.
   localparam word_type KW_TEXT [NUM_KW] = '{
      "and", "break", "do", "else", "elseif", "end", "false", "for",
      "function", "goto", "if", "in", "local", "nil", "not", "or",
      "repeat", "return", "then", "true", "until", "while"
   };

   localparam kw_len_type KW_LEN [NUM_KW] = '{
      5'd3, 5'd5, 5'd2, 5'd4, 5'd6, 5'd3, 5'd5, 5'd3, 5'd8, 5'd4, 5'd2,
      5'd2, 5'd5, 5'd3, 5'd3, 5'd2, 5'd6, 5'd6, 5'd4, 5'd4, 5'd5, 5'd5
   };

   // top-level code per keyword, identifier code when it has none
   localparam kind_type KW_TOP [NUM_KW] = '{
      5'd0,  5'd0, 5'd29, 5'd0,  5'd0,  5'd0, 5'd0, 5'd26, 5'd27, 5'd28, 5'd23,
      5'd0,  5'd30, 5'd0, 5'd0,  5'd0,  5'd25, 5'd0, 5'd0, 5'd0,  5'd0,  5'd24
   };

   // a word leaving the scanner
   typedef struct packed {
      logic      close;
      word_type  word;
      len_type   len;
      logic      began_line;
   } word_info_type;

endpackage

[hw/rtl/lwkc_scan.sv]
// Word scanner: tracks word, digit-run and line-start state per byte and
// reports a word when it closes. Depends on lwkc_pkg.
module lwkc_scan
   import lwkc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  char_type      char_code,
   input  logic          end_of_input,
   output word_info_type word_out
);

   logic     in_word_ff, in_word_in;
   logic     in_digit_ff, in_digit_in;
   logic     began_ff, began_in;
   logic     at_line_ff, at_line_in;
   len_type  len_ff, len_in;
   word_type word_ff, word_in;

   logic     is_alpha, is_digit, is_ident;
   logic     add_char, start_word;
   len_type  len_add;
   word_type word_add;

   // classify the byte
   assign is_alpha = (char_code >= CHAR_LO_A && char_code <= CHAR_LO_Z) ||
                     (char_code >= CHAR_UP_A && char_code <= CHAR_UP_Z) ||
                     (char_code == CHAR_US);
   assign is_digit = (char_code >= CHAR_0 && char_code <= CHAR_9);
   assign is_ident = is_alpha || is_digit;

   // decide whether the byte joins or starts a word
   assign start_word = !in_word_ff && !in_digit_ff && is_alpha;
   assign add_char   = in_word_ff ? is_ident : start_word;

   // word and length after adding this byte
   always_comb begin
      if (start_word) begin
         word_add = word_type'(char_code);
         len_add  = len_type'(1);
      end else begin
         word_add = word_ff;
         if (len_ff < len_type'(MAX_WORD_LEN)) begin
            word_add = {word_ff[WORD_W-CHAR_W-1:0], char_code};
         end
         len_add = (len_ff == LEN_MAX) ? len_ff : len_ff + len_type'(1);
      end
   end

   // report a word closed by a non-word byte or by end of input
   always_comb begin
      word_out.close      = (in_word_ff && !is_ident) || (end_of_input && add_char);
      word_out.word       = add_char ? word_add : word_ff;
      word_out.len        = add_char ? len_add : len_ff;
      word_out.began_line = start_word ? at_line_ff : began_ff;
   end

   // next state
   always_comb begin
      in_word_in = add_char && !end_of_input;
      len_in     = in_word_in ? len_add : '0;
      word_in    = add_char ? word_add : word_ff;
      began_in   = start_word ? at_line_ff : began_ff;
      at_line_in = end_of_input || (char_code == CHAR_LF);
      if (end_of_input || in_word_ff) begin
         in_digit_in = 1'b0;
      end else if (in_digit_ff) begin
         in_digit_in = is_ident;
      end else begin
         in_digit_in = is_digit;
      end
   end

   // advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff  <= 1'b0;
         in_digit_ff <= 1'b0;
         began_ff    <= 1'b0;
         at_line_ff  <= 1'b1;
         len_ff      <= '0;
      end else if (advance) begin
         in_word_ff  <= in_word_in;
         in_digit_ff <= in_digit_in;
         began_ff    <= began_in;
         at_line_ff  <= at_line_in;
         len_ff      <= len_in;
      end
   end

   // hold stored characters
   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

endmodule

[hw/rtl/lwkc_match.sv]
// Keyword matcher: compares a closed word against the keyword table and
// picks the token kind. Depends on lwkc_pkg.
module lwkc_match
   import lwkc_pkg::*;
(
   input  word_info_type word_in,
   input  logic          top_disable,
   output kind_type      token_kind
);

   // compare all keywords in parallel; keywords are distinct so at most one hits
   always_comb begin
      token_kind = KIND_IDENT;
      for (int k = 0; k < NUM_KW; k++) begin
         if (word_in.len == len_type'(KW_LEN[k]) && word_in.word == KW_TEXT[k]) begin
            if (KW_TOP[k] != KIND_IDENT && word_in.began_line && !top_disable) begin
               token_kind = KW_TOP[k];
            end else begin
               token_kind = kind_type'(k + 1);
            end
         end
      end
   end

endmodule

[hw/rtl/lua_word_keyword_classifier.sv]
// Top level of the Lua word keyword classifier: input register, scanner,
// matcher, result register and control register port.
// Depends on lwkc_pkg, lwkc_scan and lwkc_match.
//
//   port group  direction  carries
//   req_*       in         one source byte and its end-of-input flag per transfer
//   rsp_*       out        token kind and word length of each closed word
//   csr_*       in/out     top-level keyword disable register (upper address bit 0)
//
// One byte is taken every cycle unless a waiting result stalls; the byte that
// closes a word passes through the input register and then the result register.
// Reset is synchronous and clears control state; the disable flag resets to 1.
// A result not taken stalls the scanner; the input register keeps one byte in
// flight so a new byte is taken in the same cycle the pending result leaves.
module lua_word_keyword_classifier
   import lwkc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_char_code,
   input  logic                  req_end_of_input,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [KIND_W-1:0]     rsp_token_kind,
   output logic [LEN_W-1:0]      rsp_word_length,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic          in_valid_ff;
   char_type      in_char_ff;
   logic          in_last_ff;
   logic          out_valid_ff;
   kind_type      out_kind_ff;
   len_type       out_len_ff;
   logic          top_disable_ff;
   logic          advance;
   logic          csr_hit;
   word_info_type word_info;
   kind_type      kind;

   // move a byte out of the input register when the result slot is free or its result is taken
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_end_of_input;
      end
   end

   lwkc_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .char_code    (in_char_ff),
      .end_of_input (in_last_ff),
      .word_out     (word_info)
   );

   lwkc_match u_match (
      .word_in     (word_info),
      .top_disable (top_disable_ff),
      .token_kind  (kind)
   );

   // result register: load on a closed word, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && word_info.close) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && word_info.close) begin
         out_kind_ff <= kind;
         out_len_ff  <= word_info.len;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_token_kind  = out_kind_ff;
   assign rsp_word_length = out_len_ff;

   // control register port
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_TOP_DISABLE);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_disable_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         top_disable_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = csr_hit ? CSR_DATA_W'(top_disable_ff) : '0;

endmodule
